@@ hdl/rsi_pkg.sv @@
package rsi_pkg;

  localparam int unsigned RootW = 53;
  localparam int unsigned RemW  = 106;
  localparam int unsigned HW    = 53;

  localparam logic signed [31:0] MinDist = 32'sd66;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic                  valid;
    logic                  miss;
    logic signed [HW-1:0]  h;
    logic [RootW-1:0]      root;
    logic [RemW-1:0]       rem;
  } sq_req_t;

endpackage

@@ hdl/rsi_sqrt_cell.sv @@
module rsi_sqrt_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rsi_pkg::sq_req_t req_i,
  output rsi_pkg::sq_req_t req_o
);

  rsi_pkg::sq_req_t req_d, req_q;
  logic [rsi_pkg::RemW-1:0] trial;

  always_comb begin
    trial = (rsi_pkg::RemW'(req_i.root) << (Bit + 1))
          | (rsi_pkg::RemW'(1) << (2 * Bit));
    req_d = req_i;
    if (trial <= req_i.rem) begin
      req_d.rem  = req_i.rem - trial;
      req_d.root = req_i.root | (rsi_pkg::RootW'(1) << Bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
    end else begin
      req_q <= req_d;
    end
  end

  assign req_o = req_q;

endmodule

@@ hdl/ray_sphere_intersection.sv @@
// Ray against one sphere, fully pipelined.
// The sphere is set through the configuration channel (cfg_valid_i, cfg_ready_o,
// cfg_index_i, cfg_data_i): centre x, y, z in signed Q16.16 and the radius in
// unsigned Q15.16. cfg_ready_o is always high. The user must make writes while
// idle; the block does not enforce this. A request is taken on every edge with
// start_i high; busy_o stays low, so one ray may be issued every cycle.
// The pipeline has six arithmetic stages (difference, products, sums,
// partial squares of the linear term, discriminant, root set-up), then a row
// of 53 square-root cells, one result bit each, then the output register.
// Each result appears on distance_o and hit_o for one cycle with valid_o high.
// The receiver cannot stall; results arrive in request order.
// Reset clears the pipeline valid bits and loads centre 0 and radius 1.0.
// A ray that misses gives distance 0; hit_o marks a distance above 0.001.
module ray_sphere_intersection (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [17:0] dir_x_i,
  input  logic signed [17:0] dir_y_i,
  input  logic signed [17:0] dir_z_i,
  output logic               valid_o,
  output logic signed [31:0] distance_o,
  output logic               hit_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned Cells = rsi_pkg::RootW;

  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [30:0]        rad_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
      rad_q <= 31'd65536;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rsi_pkg::REG_CENTER_X: cx_q  <= cfg_data_i;
        rsi_pkg::REG_CENTER_Y: cy_q  <= cfg_data_i;
        rsi_pkg::REG_CENTER_Z: cz_q  <= cfg_data_i;
        rsi_pkg::REG_RADIUS:   rad_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Stage 0: offset from the centre.
  logic               v0_q;
  logic signed [32:0] dx0_q, dy0_q, dz0_q;
  logic signed [17:0] ux0_q, uy0_q, uz0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dx0_q <= 33'(origin_x_i) - 33'(cx_q);
    dy0_q <= 33'(origin_y_i) - 33'(cy_q);
    dz0_q <= 33'(origin_z_i) - 33'(cz_q);
    ux0_q <= dir_x_i;
    uy0_q <= dir_y_i;
    uz0_q <= dir_z_i;
  end

  // Stage 1: products.
  logic               v1_q;
  logic signed [50:0] px1_q, py1_q, pz1_q;
  logic signed [65:0] sx1_q, sy1_q, sz1_q;
  logic [61:0]        r21_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px1_q <= 51'(ux0_q) * 51'(dx0_q);
    py1_q <= 51'(uy0_q) * 51'(dy0_q);
    pz1_q <= 51'(uz0_q) * 51'(dz0_q);
    sx1_q <= 66'(dx0_q) * 66'(dx0_q);
    sy1_q <= 66'(dy0_q) * 66'(dy0_q);
    sz1_q <= 66'(dz0_q) * 66'(dz0_q);
    r21_q <= 62'(rad_q) * 62'(rad_q);
  end

  // Stage 2: h and q.
  logic                  v2_q;
  logic signed [52:0]    h2_q;
  logic signed [68:0]    q2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h2_q <= 53'(px1_q) + 53'(py1_q) + 53'(pz1_q);
    q2_q <= 69'(sx1_q) + 69'(sy1_q) + 69'(sz1_q) - $signed({7'd0, r21_q});
  end

  // Stage 3: h squared as three narrow partial products.
  logic               v3_q;
  logic signed [52:0] h3_q;
  logic signed [68:0] q3_q;
  logic [51:0]        phh3_q, phl3_q, pll3_q;
  logic [52:0]        habs;

  assign habs = h2_q[52] ? 53'(-h2_q) : h2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h3_q   <= h2_q;
    q3_q   <= q2_q;
    phh3_q <= habs[51:26] * habs[51:26];
    phl3_q <= habs[51:26] * habs[25:0];
    pll3_q <= habs[25:0] * habs[25:0];
  end

  // Stage 4: quarter discriminant with 64 fraction bits.
  logic                v4_q;
  logic signed [52:0]  h4_q;
  logic signed [107:0] disc4_q;
  logic [103:0]        hsq;
  logic signed [107:0] qx;

  assign hsq = (104'(phh3_q) << 52) + (104'(phl3_q) << 27) + 104'(pll3_q);
  assign qx  = 108'(q3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h4_q    <= h3_q;
    disc4_q <= $signed({4'd0, hsq}) - (qx <<< 32);
  end

  // Stage 5: square-root set-up; a negative discriminant is a miss.
  rsi_pkg::sq_req_t chain [Cells+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain[0] <= '0;
    end else begin
      chain[0].valid <= v4_q;
      chain[0].miss  <= disc4_q[107];
      chain[0].h     <= h4_q;
      chain[0].root  <= '0;
      chain[0].rem   <= disc4_q[107] ? '0 : rsi_pkg::RemW'(disc4_q[103:0]);
    end
  end

  for (genvar k = 0; k < Cells; k++) begin : g_cell
    rsi_sqrt_cell #(
      .Bit(Cells - 1 - k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .req_i (chain[k]),
      .req_o (chain[k+1])
    );
  end

  // Final stage: roots, floor to Q16.16, saturate and choose.
  rsi_pkg::sq_req_t   fin;
  logic signed [55:0] near_w, far_w;
  logic signed [39:0] near_s, far_s;
  logic signed [31:0] near_q, far_q, dist_d;
  logic               hit_d;
  logic               valid_q, hit_q;
  logic signed [31:0] dist_q;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sh007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sh0080000000) begin
      r = -32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    fin    = chain[Cells];
    near_w = -56'(fin.h) - $signed({3'd0, fin.root});
    far_w  = -56'(fin.h) + $signed({3'd0, fin.root});
    near_s = 40'(near_w >>> 16);
    far_s  = 40'(far_w >>> 16);
    near_q = sat32(near_s);
    far_q  = sat32(far_s);
    dist_d = (near_q > rsi_pkg::MinDist) ? near_q : far_q;
    if (fin.miss) begin
      dist_d = '0;
    end
    hit_d = dist_d > rsi_pkg::MinDist;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    hit_q  <= hit_d;
  end

  assign valid_o    = valid_q;
  assign distance_o = dist_q;
  assign hit_o      = hit_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##60 valid_o)
    else $error("result strobe missing sixty cycles after a request");

  a_hit_dist : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && hit_o) |-> (distance_o > rsi_pkg::MinDist))
    else $error("hit flagged at a distance below the minimum");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin.valid && fin.miss) |=> (distance_o == 32'sd0 && !hit_o))
    else $error("missed ray gave a non-zero distance");

endmodule
